// ===== hw/rtl/c8s_pkg.sv =====
// Shared types, constants and decode helpers for the 8-bit instruction step core.
`timescale 1ns / 1ps

package c8s_pkg;

	localparam int unsigned MemAddrBitsDefault = 16;
	localparam logic [15:0] PcReset = 16'hFFFA;
	localparam logic [7:0]  FlagC = 8'b00000001;
	localparam logic [7:0]  FlagZ = 8'b00000010;
	localparam logic [7:0]  FlagV = 8'b01000000;
	localparam logic [7:0]  FlagN = 8'b10000000;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_EXEC  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		M_IMP, M_IMM, M_ZP, M_ZPX, M_ZPY, M_ABS, M_ABX, M_ABY
	} mode_t;

	typedef enum logic [4:0] {
		K_BAD, K_LDA, K_LDX, K_LDY, K_STA, K_STX, K_STY, K_AND, K_EOR,
		K_ORA, K_BIT, K_CPX, K_INC, K_TAX, K_TAY, K_TXA, K_TYA, K_INX, K_INY
	} kind_t;

	typedef struct packed {
		kind_t kind;
		mode_t mode;
	} dec_t;

	typedef enum logic [2:0] {
		ALU_ADD, ALU_SUB, ALU_AND, ALU_EOR, ALU_ORA
	} alu_op_t;

	typedef struct packed {
		alu_op_t     op;
		logic [15:0] a;
		logic [15:0] b;
	} alu_req_t;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_HOST, ST_HOSTRD, ST_FETCH, ST_DECODE,
		ST_OPLO, ST_OPHI, ST_ACCESS, ST_EXEC, ST_INCWR, ST_DONE
	} st_t;

	function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
		logic [7:0] r;
		r = p & ~(FlagN | FlagZ);
		if (v == 8'h00) r = r | FlagZ;
		if (v[7]) r = r | FlagN;
		return r;
	endfunction

	function automatic dec_t decode(input logic [7:0] op);
		dec_t d;
		d.mode = M_IMP;
		d.kind = K_BAD;
		unique case (op)
			8'hA9: begin d.kind = K_LDA; d.mode = M_IMM; end
			8'hA5: begin d.kind = K_LDA; d.mode = M_ZP;  end
			8'hB5: begin d.kind = K_LDA; d.mode = M_ZPX; end
			8'hAD: begin d.kind = K_LDA; d.mode = M_ABS; end
			8'hBD: begin d.kind = K_LDA; d.mode = M_ABX; end
			8'hB9: begin d.kind = K_LDA; d.mode = M_ABY; end
			8'hA2: begin d.kind = K_LDX; d.mode = M_IMM; end
			8'hA6: begin d.kind = K_LDX; d.mode = M_ZP;  end
			8'hB6: begin d.kind = K_LDX; d.mode = M_ZPY; end
			8'hAE: begin d.kind = K_LDX; d.mode = M_ABS; end
			8'hBE: begin d.kind = K_LDX; d.mode = M_ABY; end
			8'hA0: begin d.kind = K_LDY; d.mode = M_IMM; end
			8'hA4: begin d.kind = K_LDY; d.mode = M_ZP;  end
			8'hB4: begin d.kind = K_LDY; d.mode = M_ZPX; end
			8'hAC: begin d.kind = K_LDY; d.mode = M_ABS; end
			8'hBC: begin d.kind = K_LDY; d.mode = M_ABX; end
			8'h85: begin d.kind = K_STA; d.mode = M_ZP;  end
			8'h95: begin d.kind = K_STA; d.mode = M_ZPX; end
			8'h8D: begin d.kind = K_STA; d.mode = M_ABS; end
			8'h9D: begin d.kind = K_STA; d.mode = M_ABX; end
			8'h99: begin d.kind = K_STA; d.mode = M_ABY; end
			8'h86: begin d.kind = K_STX; d.mode = M_ZP;  end
			8'h96: begin d.kind = K_STX; d.mode = M_ZPY; end
			8'h8E: begin d.kind = K_STX; d.mode = M_ABS; end
			8'h84: begin d.kind = K_STY; d.mode = M_ZP;  end
			8'h94: begin d.kind = K_STY; d.mode = M_ZPX; end
			8'h8C: begin d.kind = K_STY; d.mode = M_ABS; end
			8'hAA: d.kind = K_TAX;
			8'hA8: d.kind = K_TAY;
			8'h8A: d.kind = K_TXA;
			8'h98: d.kind = K_TYA;
			8'h29: begin d.kind = K_AND; d.mode = M_IMM; end
			8'h25: begin d.kind = K_AND; d.mode = M_ZP;  end
			8'h35: begin d.kind = K_AND; d.mode = M_ZPX; end
			8'h2D: begin d.kind = K_AND; d.mode = M_ABS; end
			8'h3D: begin d.kind = K_AND; d.mode = M_ABX; end
			8'h39: begin d.kind = K_AND; d.mode = M_ABY; end
			8'h49: begin d.kind = K_EOR; d.mode = M_IMM; end
			8'h45: begin d.kind = K_EOR; d.mode = M_ZP;  end
			8'h55: begin d.kind = K_EOR; d.mode = M_ZPX; end
			8'h4D: begin d.kind = K_EOR; d.mode = M_ABS; end
			8'h5D: begin d.kind = K_EOR; d.mode = M_ABX; end
			8'h59: begin d.kind = K_EOR; d.mode = M_ABY; end
			8'h09: begin d.kind = K_ORA; d.mode = M_IMM; end
			8'h05: begin d.kind = K_ORA; d.mode = M_ZP;  end
			8'h15: begin d.kind = K_ORA; d.mode = M_ZPX; end
			8'h0D: begin d.kind = K_ORA; d.mode = M_ABS; end
			8'h1D: begin d.kind = K_ORA; d.mode = M_ABX; end
			8'h19: begin d.kind = K_ORA; d.mode = M_ABY; end
			8'h24: begin d.kind = K_BIT; d.mode = M_ZP;  end
			8'h2C: begin d.kind = K_BIT; d.mode = M_ABS; end
			8'hE0: begin d.kind = K_CPX; d.mode = M_IMM; end
			8'hE4: begin d.kind = K_CPX; d.mode = M_ZP;  end
			8'hEC: begin d.kind = K_CPX; d.mode = M_ABS; end
			8'hE6: begin d.kind = K_INC; d.mode = M_ZP;  end
			8'hF6: begin d.kind = K_INC; d.mode = M_ZPX; end
			8'hEE: begin d.kind = K_INC; d.mode = M_ABS; end
			8'hFE: begin d.kind = K_INC; d.mode = M_ABX; end
			8'hE8: d.kind = K_INX;
			8'hC8: d.kind = K_INY;
			default: d.kind = K_BAD;
		endcase
		return d;
	endfunction

endpackage

// ===== hw/rtl/c8s_if.sv =====
// Request and result channel interfaces of the instruction step core.
`timescale 1ns / 1ps

interface c8s_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [15:0] mem_addr;
	logic [7:0]  mem_data;

	modport source (output valid, cmd, mem_addr, mem_data, input ready);
	modport sink (input valid, cmd, mem_addr, mem_data, output ready);
endinterface

interface c8s_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  read_data;
	logic [15:0] pc_out;
	logic [7:0]  acc_out;
	logic [7:0]  x_out;
	logic [7:0]  y_out;
	logic [7:0]  status_out;
	logic        unsupported;

	modport source (output valid, read_data, pc_out, acc_out, x_out, y_out, status_out,
		unsupported, input ready);
	modport sink (input valid, read_data, pc_out, acc_out, x_out, y_out, status_out,
		unsupported, output ready);
endinterface

// ===== hw/rtl/c8s_mem.sv =====
// Single-port byte memory with registered read data.
`timescale 1ns / 1ps

module c8s_mem #(
	parameter int unsigned MEM_ADDR_BITS = c8s_pkg::MemAddrBitsDefault
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [MEM_ADDR_BITS-1:0] addr,
	input  logic [7:0]               wdata,
	output logic [7:0]               rdata
);

	logic [7:0] mem_q [2**MEM_ADDR_BITS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// ===== hw/rtl/c8s_alu.sv =====
// Shared adder, subtractor and logic unit.
`timescale 1ns / 1ps

module c8s_alu (
	input  c8s_pkg::alu_req_t req,
	output logic [16:0]       res
);

	always_comb begin
		unique case (req.op)
			c8s_pkg::ALU_ADD: res = {1'b0, req.a} + {1'b0, req.b};
			c8s_pkg::ALU_SUB: res = {1'b0, req.a} - {1'b0, req.b};
			c8s_pkg::ALU_AND: res = {1'b0, req.a & req.b};
			c8s_pkg::ALU_EOR: res = {1'b0, req.a ^ req.b};
			c8s_pkg::ALU_ORA: res = {1'b0, req.a | req.b};
			default:          res = 17'd0;
		endcase
	end

endmodule

// ===== hw/rtl/cpu8_instruction_step.sv =====
// Top level: sequencer, architectural registers and result register of the step core.
// Host writes pass ST_HOST, reads also ST_HOSTRD; execution starts at ST_FETCH.
// Throughput: one request at a time, taken in ST_IDLE; single port, one access a cycle.
// Unsupported opcode: done after ST_DECODE, flag set; unused command: straight to ST_DONE.
// Reset: PC to 0xFFFA, A/X/Y/P cleared, then a clearing pass over all 2**MEM_ADDR_BITS
// addresses zeroes the memory before the first request is taken.
`timescale 1ns / 1ps

module cpu8_instruction_step #(
	parameter int unsigned MEM_ADDR_BITS = c8s_pkg::MemAddrBitsDefault
) (
	input  logic             clk,
	input  logic             arst_n,
	c8s_in_if.sink           in_ch,
	c8s_out_if.source        out_ch
);

	localparam int unsigned AW = MEM_ADDR_BITS;

	c8s_pkg::st_t     state_q, state_d;
	c8s_pkg::cmd_t    cmd_q;
	c8s_pkg::kind_t   kind_q;
	c8s_pkg::mode_t   mode_q;
	c8s_pkg::dec_t    dec;
	c8s_pkg::alu_req_t alu_req;

	logic [AW-1:0] clr_q;
	logic [15:0]   haddr_q;
	logic [7:0]    hdata_q;
	logic [15:0]   pc_q;
	logic [7:0]    a_q, x_q, y_q, p_q;
	logic [7:0]    rd_q;
	logic          bad_q;
	logic [7:0]    lo_q;
	logic [15:0]   ea_q;
	logic [7:0]    res_q;

	logic          mem_we;
	logic [15:0]   mem_sel;
	logic [AW-1:0] mem_a;
	logic [7:0]    mem_wd, mem_rd;
	logic [16:0]   alu_res;
	logic [7:0]    idx;
	logic [7:0]    st_data;
	logic          accept;

	assign accept = in_ch.valid && in_ch.ready;
	assign dec    = c8s_pkg::decode(mem_rd);
	assign idx    = (mode_q == c8s_pkg::M_ZPY || mode_q == c8s_pkg::M_ABY) ? y_q :
		(mode_q == c8s_pkg::M_ZPX || mode_q == c8s_pkg::M_ABX) ? x_q : 8'h00;
	assign st_data = (kind_q == c8s_pkg::K_STX) ? x_q :
		(kind_q == c8s_pkg::K_STY) ? y_q : a_q;
	assign mem_a  = (state_q == c8s_pkg::ST_CLEAR) ? clr_q : mem_sel[AW-1:0];

	c8s_mem #(.MEM_ADDR_BITS(MEM_ADDR_BITS)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_a),
		.wdata (mem_wd),
		.rdata (mem_rd)
	);

	c8s_alu u_alu (
		.req (alu_req),
		.res (alu_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= c8s_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, memory port and ALU operand selection
	always_comb begin
		state_d     = state_q;
		mem_we      = 1'b0;
		mem_sel     = pc_q;
		mem_wd      = 8'h00;
		alu_req.op  = c8s_pkg::ALU_ADD;
		alu_req.a   = 16'h0000;
		alu_req.b   = 16'h0000;
		unique case (state_q)
			c8s_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
				if (clr_q == {AW{1'b1}}) state_d = c8s_pkg::ST_IDLE;
			end
			c8s_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (c8s_pkg::cmd_t'(in_ch.cmd))
						c8s_pkg::CMD_WRITE, c8s_pkg::CMD_READ: state_d = c8s_pkg::ST_HOST;
						c8s_pkg::CMD_EXEC: state_d = c8s_pkg::ST_FETCH;
						default:           state_d = c8s_pkg::ST_DONE;
					endcase
				end
			end
			c8s_pkg::ST_HOST: begin
				mem_sel = haddr_q;
				mem_wd  = hdata_q;
				mem_we  = (cmd_q == c8s_pkg::CMD_WRITE);
				state_d = (cmd_q == c8s_pkg::CMD_WRITE) ? c8s_pkg::ST_DONE : c8s_pkg::ST_HOSTRD;
			end
			c8s_pkg::ST_HOSTRD: state_d = c8s_pkg::ST_DONE;
			c8s_pkg::ST_FETCH:  state_d = c8s_pkg::ST_DECODE;
			c8s_pkg::ST_DECODE: begin
				priority if (dec.kind == c8s_pkg::K_BAD) state_d = c8s_pkg::ST_DONE;
				else if (dec.mode == c8s_pkg::M_IMP) state_d = c8s_pkg::ST_EXEC;
				else if (dec.mode == c8s_pkg::M_IMM) state_d = c8s_pkg::ST_ACCESS;
				else state_d = c8s_pkg::ST_OPLO;
			end
			c8s_pkg::ST_OPLO: begin
				// zero page base plus index, wrapped to page zero below
				alu_req.a = {8'h00, mem_rd};
				alu_req.b = {8'h00, idx};
				if (mode_q == c8s_pkg::M_ABS || mode_q == c8s_pkg::M_ABX ||
						mode_q == c8s_pkg::M_ABY) begin
					state_d = c8s_pkg::ST_OPHI;
				end else begin
					state_d = c8s_pkg::ST_ACCESS;
				end
			end
			c8s_pkg::ST_OPHI: begin
				alu_req.a = {mem_rd, lo_q};
				alu_req.b = {8'h00, idx};
				state_d   = c8s_pkg::ST_ACCESS;
			end
			c8s_pkg::ST_ACCESS: begin
				mem_sel = ea_q;
				mem_wd  = st_data;
				if (kind_q == c8s_pkg::K_STA || kind_q == c8s_pkg::K_STX ||
						kind_q == c8s_pkg::K_STY) begin
					mem_we  = 1'b1;
					state_d = c8s_pkg::ST_DONE;
				end else begin
					state_d = c8s_pkg::ST_EXEC;
				end
			end
			c8s_pkg::ST_EXEC: begin
				state_d = (kind_q == c8s_pkg::K_INC) ? c8s_pkg::ST_INCWR : c8s_pkg::ST_DONE;
				unique case (kind_q)
					c8s_pkg::K_LDA, c8s_pkg::K_LDX, c8s_pkg::K_LDY: begin
						alu_req.op = c8s_pkg::ALU_ORA;
						alu_req.b  = {8'h00, mem_rd};
					end
					c8s_pkg::K_AND, c8s_pkg::K_BIT: begin
						alu_req.op = c8s_pkg::ALU_AND;
						alu_req.a  = {8'h00, a_q};
						alu_req.b  = {8'h00, mem_rd};
					end
					c8s_pkg::K_EOR: begin
						alu_req.op = c8s_pkg::ALU_EOR;
						alu_req.a  = {8'h00, a_q};
						alu_req.b  = {8'h00, mem_rd};
					end
					c8s_pkg::K_ORA: begin
						alu_req.op = c8s_pkg::ALU_ORA;
						alu_req.a  = {8'h00, a_q};
						alu_req.b  = {8'h00, mem_rd};
					end
					c8s_pkg::K_CPX: begin
						alu_req.op = c8s_pkg::ALU_SUB;
						alu_req.a  = {8'h00, x_q};
						alu_req.b  = {8'h00, mem_rd};
					end
					c8s_pkg::K_INC: begin
						alu_req.a = {8'h00, mem_rd};
						alu_req.b = 16'h0001;
					end
					c8s_pkg::K_TAX, c8s_pkg::K_TAY: begin
						alu_req.op = c8s_pkg::ALU_ORA;
						alu_req.a  = {8'h00, a_q};
					end
					c8s_pkg::K_TXA, c8s_pkg::K_INX: begin
						alu_req.op = (kind_q == c8s_pkg::K_INX) ? c8s_pkg::ALU_ADD :
							c8s_pkg::ALU_ORA;
						alu_req.a  = {8'h00, x_q};
						alu_req.b  = (kind_q == c8s_pkg::K_INX) ? 16'h0001 : 16'h0000;
					end
					c8s_pkg::K_TYA, c8s_pkg::K_INY: begin
						alu_req.op = (kind_q == c8s_pkg::K_INY) ? c8s_pkg::ALU_ADD :
							c8s_pkg::ALU_ORA;
						alu_req.a  = {8'h00, y_q};
						alu_req.b  = (kind_q == c8s_pkg::K_INY) ? 16'h0001 : 16'h0000;
					end
					default: ;
				endcase
			end
			c8s_pkg::ST_INCWR: begin
				mem_sel = ea_q;
				mem_wd  = res_q;
				mem_we  = 1'b1;
				state_d = c8s_pkg::ST_DONE;
			end
			c8s_pkg::ST_DONE: begin
				if (out_ch.ready) state_d = c8s_pkg::ST_IDLE;
			end
			default: state_d = c8s_pkg::ST_IDLE;
		endcase
	end

	// Architectural registers, memory clear counter and read/unsupported result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			pc_q  <= c8s_pkg::PcReset;
			a_q   <= 8'h00;
			x_q   <= 8'h00;
			y_q   <= 8'h00;
			p_q   <= 8'h00;
			rd_q  <= 8'h00;
			bad_q <= 1'b0;
		end else begin
			unique case (state_q)
				c8s_pkg::ST_CLEAR: clr_q <= clr_q + 1'b1;
				c8s_pkg::ST_IDLE: begin
					if (accept) begin
						rd_q  <= 8'h00;
						bad_q <= 1'b0;
					end
				end
				c8s_pkg::ST_HOSTRD: rd_q <= mem_rd;
				c8s_pkg::ST_FETCH:  pc_q <= pc_q + 16'd1;
				c8s_pkg::ST_DECODE: begin
					if (dec.kind == c8s_pkg::K_BAD) begin
						bad_q <= 1'b1;
					end else if (dec.mode != c8s_pkg::M_IMP) begin
						pc_q <= pc_q + 16'd1;
					end
				end
				c8s_pkg::ST_OPLO: begin
					if (mode_q == c8s_pkg::M_ABS || mode_q == c8s_pkg::M_ABX ||
							mode_q == c8s_pkg::M_ABY) begin
						pc_q <= pc_q + 16'd1;
					end
				end
				c8s_pkg::ST_EXEC: begin
					unique case (kind_q)
						c8s_pkg::K_LDA, c8s_pkg::K_AND, c8s_pkg::K_EOR, c8s_pkg::K_ORA,
						c8s_pkg::K_TXA, c8s_pkg::K_TYA: begin
							a_q <= alu_res[7:0];
							p_q <= c8s_pkg::set_nz(p_q, alu_res[7:0]);
						end
						c8s_pkg::K_LDX, c8s_pkg::K_TAX, c8s_pkg::K_INX: begin
							x_q <= alu_res[7:0];
							p_q <= c8s_pkg::set_nz(p_q, alu_res[7:0]);
						end
						c8s_pkg::K_LDY, c8s_pkg::K_TAY, c8s_pkg::K_INY: begin
							y_q <= alu_res[7:0];
							p_q <= c8s_pkg::set_nz(p_q, alu_res[7:0]);
						end
						c8s_pkg::K_BIT: begin
							p_q <= (p_q & ~(c8s_pkg::FlagN | c8s_pkg::FlagV | c8s_pkg::FlagZ))
								| (mem_rd & (c8s_pkg::FlagN | c8s_pkg::FlagV))
								| ((alu_res[7:0] == 8'h00) ? c8s_pkg::FlagZ : 8'h00);
						end
						c8s_pkg::K_CPX: begin
							// no borrow out means X >= M
							p_q <= (c8s_pkg::set_nz(p_q, alu_res[7:0]) & ~c8s_pkg::FlagC)
								| (alu_res[16] ? 8'h00 : c8s_pkg::FlagC);
						end
						c8s_pkg::K_INC: p_q <= c8s_pkg::set_nz(p_q, alu_res[7:0]);
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (state_q == c8s_pkg::ST_IDLE && accept) begin
			cmd_q   <= c8s_pkg::cmd_t'(in_ch.cmd);
			haddr_q <= in_ch.mem_addr;
			hdata_q <= in_ch.mem_data;
		end
		if (state_q == c8s_pkg::ST_DECODE) begin
			kind_q <= dec.kind;
			mode_q <= dec.mode;
			ea_q   <= pc_q;
		end
		if (state_q == c8s_pkg::ST_OPLO) begin
			lo_q <= mem_rd;
			ea_q <= {8'h00, alu_res[7:0]};
		end
		if (state_q == c8s_pkg::ST_OPHI) begin
			ea_q <= alu_res[15:0];
		end
		if (state_q == c8s_pkg::ST_EXEC) begin
			res_q <= alu_res[7:0];
		end
	end

	assign in_ch.ready        = (state_q == c8s_pkg::ST_IDLE);
	assign out_ch.valid       = (state_q == c8s_pkg::ST_DONE);
	assign out_ch.read_data   = rd_q;
	assign out_ch.pc_out      = pc_q;
	assign out_ch.acc_out     = a_q;
	assign out_ch.x_out       = x_q;
	assign out_ch.y_out       = y_q;
	assign out_ch.status_out  = p_q;
	assign out_ch.unsupported = bad_q;

`ifndef SYNTHESIS
	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !out_ch.valid)
		else $error("request taken while a result is pending");
	a_bad_exec: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.unsupported |-> cmd_q == c8s_pkg::CMD_EXEC)
		else $error("unsupported flag on a host command");
	a_rd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && cmd_q != c8s_pkg::CMD_READ |-> out_ch.read_data == 8'h00)
		else $error("read data not zero outside a read");
	a_flags_fixed: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> out_ch.status_out[5:2] == 4'h0)
		else $error("I, D, B or bit 5 changed");
	a_clear_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == c8s_pkg::ST_CLEAR |-> !in_ch.ready && !out_ch.valid)
		else $error("handshake during memory clear");
`endif

endmodule
